@@ rtl/core/exposure_adaptation_top_macros.svh @@
// ----------------------------------------------------------------------------
// exposure adaptation assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef EXPOSURE_ADAPTATION_TOP_MACROS_SVH
`define EXPOSURE_ADAPTATION_TOP_MACROS_SVH

// same-cycle implication
`define EXAD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("exposure adaptation check failed");

// next-cycle implication
`define EXAD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("exposure adaptation check failed");

`endif

@@ rtl/core/exad_pkg.sv @@
// ----------------------------------------------------------------------------
// exposure adaptation package
// constants, register indexes and sequencer states
// ----------------------------------------------------------------------------
package exad_pkg;

   localparam logic [15:0] DT_MAX          = 16'd6554;
   localparam logic [31:0] LUM_FLOOR       = 32'd7;
   localparam logic [15:0] KEY_DEFAULT     = 16'd11796;
   localparam logic [31:0] MIN_EXP_DEFAULT = 32'd7;
   localparam logic [31:0] RECIP3          = 32'hAAAA_AAAB;
   localparam int          DIV_STEPS       = 40;
   localparam int          SQ_STEPS        = 8;

   localparam logic        CMD_FRAME       = 1'b0;
   localparam logic        CMD_SEED        = 1'b1;

   typedef enum logic [2:0] {
      CSR_KEY_VALUE    = 3'd0,
      CSR_COMPENSATION = 3'd1,
      CSR_MIN_EXPOSURE = 3'd2,
      CSR_MAX_EXPOSURE = 3'd3,
      CSR_SPEED_UP     = 3'd4,
      CSR_SPEED_DOWN   = 3'd5
   } csr_index_type;

   typedef enum logic [16:0] {
      ST_IDLE = 17'h00001,
      ST_KC   = 17'h00002,
      ST_DLD  = 17'h00004,
      ST_DIV  = 17'h00008,
      ST_TGT  = 17'h00010,
      ST_X    = 17'h00020,
      ST_Z2   = 17'h00040,
      ST_Z3   = 17'h00080,
      ST_Z4   = 17'h00100,
      ST_D6   = 17'h00200,
      ST_D24  = 17'h00400,
      ST_SER  = 17'h00800,
      ST_SQI  = 17'h01000,
      ST_SQW  = 17'h02000,
      ST_MUL  = 17'h04000,
      ST_UPD  = 17'h08000,
      ST_OUT  = 17'h10000
   } state_type;

endpackage

@@ rtl/core/exposure_adaptation_top.sv @@
// ----------------------------------------------------------------------------
// a seed or ignored frame goes straight to ST_OUT; a frame runs the 40-step divider,
// and an adapting frame also the decay series on the shared 32x32 multiplier,
// which it skips when the selected rate or the frame time is zero
// one request at a time: a new request is taken only after the result is accepted
// synchronous reset: limits and rates to defaults, exposure state cleared
// ----------------------------------------------------------------------------
module exposure_adaptation_top
   import exad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [31:0] req_avg_luminance,
   input  logic        req_measure_valid,
   input  logic [15:0] req_frame_time,
   input  logic        req_enable,
   input  logic [31:0] req_seed_exposure,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_exposure,
   output logic [31:0] rsp_target_exposure,
   output logic        rsp_applied,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   state_type   state_ff, state_in;
   logic [15:0] key_ff, comp_ff, sup_ff, sdn_ff;
   logic [31:0] min_ff, max_ff;
   logic [31:0] exp_ff, exp_in, tgt_ff, tgt_in;
   logic        have_ff, have_in, en_ff, en_in, applied_ff, applied_in;
   logic [31:0] lum_ff, lum_in;
   logic [15:0] dt_ff, dt_in, speed_ff, speed_in;
   logic [39:0] num_ff, num_in, quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] z_ff, z_in, z2_ff, z2_in, z3_ff, z3_in, z4_ff, z4_in;
   logic [30:0] q6_ff, q6_in;
   logic [31:0] e_ff, e_in, d_ff, d_in;
   logic [32:0] alpha_ff, alpha_in;
   logic        up_ff, up_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] mul_a, mul_b;
   logic [32:0] trial;
   logic [31:0] lo, hi, lo_s, hi_s, tsat, tclamp;
   logic [33:0] e_sum;
   logic [63:0] rnd;
   logic [31:0] step;

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = (state_ff == ST_OUT);
   assign rsp_exposure        = exp_ff;
   assign rsp_target_exposure = tgt_ff;
   assign rsp_applied         = applied_ff;
   assign csr_ready           = 1'b1;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_KC: begin
            mul_a = {16'd0, (key_ff != 16'd0) ? key_ff : KEY_DEFAULT};
            mul_b = {16'd0, comp_ff};
         end
         ST_X: begin
            mul_a = {16'd0, speed_ff};
            mul_b = {16'd0, dt_ff};
         end
         ST_Z2: begin
            mul_a = prod_ff[31:0];
            mul_b = prod_ff[31:0];
         end
         ST_Z3, ST_Z4: begin
            mul_a = prod_ff[63:32];
            mul_b = z_ff;
         end
         ST_D6: begin
            mul_a = {1'b0, z3_ff[31:1]};
            mul_b = RECIP3;
         end
         ST_D24: begin
            mul_a = {3'd0, z4_ff[31:3]};
            mul_b = RECIP3;
         end
         ST_SQI: begin
            mul_a = e_ff;
            mul_b = e_ff;
         end
         ST_MUL: begin
            mul_a = d_ff;
            mul_b = alpha_ff[31:0];
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign prod_in = {32'd0, mul_a} * {32'd0, mul_b};
   assign trial   = {rem_ff, num_ff[39]};

   always_comb begin
      lo     = (min_ff != 32'd0) ? min_ff : MIN_EXP_DEFAULT;
      hi     = (max_ff != 32'd0) ? max_ff : lo;
      lo_s   = (hi < lo) ? hi : lo;
      hi_s   = (hi < lo) ? lo : hi;
      tsat   = (quo_ff[39:32] != 8'd0) ? 32'hFFFF_FFFF : quo_ff[31:0];
      tclamp = (tsat < lo_s) ? lo_s : ((tsat > hi_s) ? hi_s : tsat);
      e_sum  = 34'h1_0000_0000 - {2'd0, z_ff} + {3'd0, z2_ff[31:1]}
               - {3'd0, q6_ff} + {3'd0, prod_ff[63:33]};
      rnd    = prod_ff + 64'h0000_0000_8000_0000;
      step   = alpha_ff[32] ? d_ff : rnd[63:32];
   end

   always_comb begin
      state_in   = state_ff;
      exp_in     = exp_ff;
      tgt_in     = tgt_ff;
      have_in    = have_ff;
      en_in      = en_ff;
      applied_in = applied_ff;
      lum_in     = lum_ff;
      dt_in      = dt_ff;
      speed_in   = speed_ff;
      num_in     = num_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      z_in       = z_ff;
      z2_in      = z2_ff;
      z3_in      = z3_ff;
      z4_in      = z4_ff;
      q6_in      = q6_ff;
      e_in       = e_ff;
      d_in       = d_ff;
      alpha_in   = alpha_ff;
      up_in      = up_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               applied_in = 1'b0;
               state_in   = ST_OUT;
               if (req_cmd == CMD_SEED) begin
                  en_in = req_enable;
                  if (req_enable) begin
                     if (req_seed_exposure != 32'd0) begin
                        exp_in  = req_seed_exposure;
                        have_in = 1'b1;
                     end else begin
                        have_in = 1'b0;
                     end
                  end
               end else if (en_ff && req_measure_valid && req_avg_luminance != 32'd0) begin
                  lum_in   = (req_avg_luminance < LUM_FLOOR) ? LUM_FLOOR : req_avg_luminance;
                  dt_in    = (req_frame_time > DT_MAX) ? DT_MAX : req_frame_time;
                  state_in = ST_KC;
               end
            end
         end
         ST_KC: begin
            state_in = ST_DLD;
         end
         ST_DLD: begin
            num_in   = {prod_ff[31:0], 8'd0};
            rem_in   = 32'd0;
            quo_in   = 40'd0;
            cnt_in   = 6'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            num_in = {num_ff[38:0], 1'b0};
            if (trial >= {1'b0, lum_ff}) begin
               rem_in = 32'(trial - {1'b0, lum_ff});
               quo_in = {quo_ff[38:0], 1'b1};
            end else begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[38:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ST_TGT;
            end
         end
         ST_TGT: begin
            tgt_in     = tclamp;
            applied_in = 1'b1;
            if (!have_ff || exp_ff == 32'd0) begin
               exp_in   = tclamp;
               have_in  = 1'b1;
               state_in = ST_OUT;
            end else begin
               up_in    = (tclamp >= exp_ff);
               d_in     = (tclamp >= exp_ff) ? (tclamp - exp_ff) : (exp_ff - tclamp);
               speed_in = (tclamp > exp_ff) ? sup_ff : sdn_ff;
               if (((tclamp > exp_ff) ? sup_ff : sdn_ff) == 16'd0) begin
                  alpha_in = 33'h1_0000_0000;
                  state_in = ST_MUL;
               end else if (dt_ff == 16'd0) begin
                  alpha_in = 33'd0;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_X;
               end
            end
         end
         ST_X: begin
            state_in = ST_Z2;
         end
         ST_Z2: begin
            z_in     = prod_ff[31:0];
            state_in = ST_Z3;
         end
         ST_Z3: begin
            z2_in    = prod_ff[63:32];
            state_in = ST_Z4;
         end
         ST_Z4: begin
            z3_in    = prod_ff[63:32];
            state_in = ST_D6;
         end
         ST_D6: begin
            z4_in    = prod_ff[63:32];
            state_in = ST_D24;
         end
         ST_D24: begin
            q6_in    = prod_ff[63:33];
            state_in = ST_SER;
         end
         ST_SER: begin
            e_in     = e_sum[31:0];
            cnt_in   = 6'd0;
            state_in = ST_SQI;
         end
         ST_SQI: begin
            state_in = ST_SQW;
         end
         ST_SQW: begin
            e_in   = prod_ff[63:32];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(SQ_STEPS - 1)) begin
               alpha_in = 33'h1_0000_0000 - {1'b0, prod_ff[63:32]};
               state_in = ST_MUL;
            end else begin
               state_in = ST_SQI;
            end
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            exp_in   = up_ff ? (exp_ff + step) : (exp_ff - step);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         key_ff     <= KEY_DEFAULT;
         comp_ff    <= 16'd256;
         min_ff     <= MIN_EXP_DEFAULT;
         max_ff     <= 32'd1048576;
         sup_ff     <= 16'd768;
         sdn_ff     <= 16'd256;
         exp_ff     <= 32'd0;
         tgt_ff     <= 32'd0;
         have_ff    <= 1'b0;
         en_ff      <= 1'b0;
         applied_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         exp_ff     <= exp_in;
         tgt_ff     <= tgt_in;
         have_ff    <= have_in;
         en_ff      <= en_in;
         applied_ff <= applied_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_KEY_VALUE:    key_ff  <= csr_data[15:0];
               CSR_COMPENSATION: comp_ff <= csr_data[15:0];
               CSR_MIN_EXPOSURE: min_ff  <= csr_data;
               CSR_MAX_EXPOSURE: max_ff  <= csr_data;
               CSR_SPEED_UP:     sup_ff  <= csr_data[15:0];
               CSR_SPEED_DOWN:   sdn_ff  <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      lum_ff   <= lum_in;
      dt_ff    <= dt_in;
      speed_ff <= speed_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      z_ff     <= z_in;
      z2_ff    <= z2_in;
      z3_ff    <= z3_in;
      z4_ff    <= z4_in;
      q6_ff    <= q6_in;
      e_ff     <= e_in;
      d_ff     <= d_in;
      alpha_ff <= alpha_in;
      up_ff    <= up_in;
      prod_ff  <= prod_in;
   end

endmodule

@@ rtl/core/exad_checker.sv @@
// ----------------------------------------------------------------------------
// exposure adaptation checker
// port-level checks on request and result sequencing
// ----------------------------------------------------------------------------
`include "exposure_adaptation_top_macros.svh"

module exad_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_exposure
);

   `EXAD_ASSERT_NEXT(busy_after_request, clock, reset, req_valid && req_ready, !req_ready)
   `EXAD_ASSERT_NOW(no_request_while_result, clock, reset, rsp_valid, !req_ready)
   `EXAD_ASSERT_NEXT(result_held, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_exposure))
   `EXAD_ASSERT_NEXT(reset_to_idle, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind exposure_adaptation_top exad_checker u_exad_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_exposure (rsp_exposure)
);

@@ verif/tb_exposure_adaptation_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exposure adaptation testbench
// drives frame and seed requests with random gaps, predicts exposure, target
// and applied for each request and compares every response in order
// ----------------------------------------------------------------------------
module tb_exposure_adaptation_top;
   import exad_pkg::*;

   localparam int   STALL_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] exposure;
      logic [31:0] target;
      logic        applied;
   } exposure_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [31:0] req_avg_luminance = '0;
   logic        req_measure_valid = 1'b0;
   logic [15:0] req_frame_time = '0;
   logic        req_enable = 1'b0;
   logic [31:0] req_seed_exposure = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_exposure;
   logic [31:0] rsp_target_exposure;
   logic        rsp_applied;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // predictor state
   logic [31:0] key_q, comp_q, min_q, max_q, up_q, down_q;
   logic [31:0] exp_q, tgt_q;
   logic        have_q, en_q;

   exposure_result_type expected_q[$];
   int errors = 0;
   int idle_cycles = 0;

   exposure_adaptation_top DUT (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [63:0] decay(input logic [31:0] x);
      logic [63:0] z, z2, z3, z4, e;
      z = {32'd0, x};
      z2 = (z * z) >> 32;
      z3 = (z2 * z) >> 32;
      z4 = (z3 * z) >> 32;
      e = 64'h1_0000_0000 - z + z2 / 2;
      e = e - z3 / 6 + z4 / 24;
      for (int i = 0; i < 8; i++) e = (e * e) >> 32;
      return e;
   endfunction

   function automatic exposure_result_type predict_exposure(input logic cmd,
         input logic [31:0] lum_in, input logic mvalid, input logic [15:0] dt_in,
         input logic en, input logic [31:0] seed);
      exposure_result_type r;
      logic [31:0] lum, lo, hi, sw, target, speed;
      logic [15:0] dt;
      logic [63:0] key, t, alpha, d, step;
      r.applied = 1'b0;
      if (cmd == CMD_SEED) begin
         en_q = en;
         if (en) begin
            if (seed != 0) begin
               exp_q = seed;
               have_q = 1'b1;
            end else begin
               have_q = 1'b0;
            end
         end
      end else if (en_q && mvalid && lum_in != 0) begin
         key = 64'((key_q != 0) ? key_q : {16'd0, KEY_DEFAULT});
         lo = (min_q != 0) ? min_q : MIN_EXP_DEFAULT;
         hi = (max_q != 0) ? max_q : lo;
         dt = (dt_in > DT_MAX) ? DT_MAX : dt_in;
         lum = (lum_in < LUM_FLOOR) ? LUM_FLOOR : lum_in;
         if (hi < lo) begin
            sw = hi; hi = lo; lo = sw;
         end
         t = (key * comp_q * 256) / lum;
         if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
         target = t[31:0];
         if (target < lo) target = lo;
         if (target > hi) target = hi;
         tgt_q = target;
         if (!have_q || exp_q == 0) begin
            exp_q = target;
            have_q = 1'b1;
         end else begin
            speed = (target > exp_q) ? up_q : down_q;
            if (speed == 0) alpha = 64'h1_0000_0000;
            else if (dt == 0) alpha = 64'd0;
            else alpha = 64'h1_0000_0000 - decay(speed * dt);
            if (target >= exp_q) begin
               d = 64'(target - exp_q);
               step = (d * alpha + 64'h8000_0000) >> 32;
               exp_q = exp_q + step[31:0];
            end else begin
               d = 64'(exp_q - target);
               step = (d * alpha + 64'h8000_0000) >> 32;
               exp_q = exp_q - step[31:0];
            end
         end
         r.applied = 1'b1;
      end
      r.exposure = exp_q;
      r.target = tgt_q;
      return r;
   endfunction

   // response side: random stall per response, checked against oldest request
   initial begin
      int gap;
      exposure_result_type e;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t unexpected response exp %h tgt %h app %b", $time,
                  rsp_exposure, rsp_target_exposure, rsp_applied);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_exposure !== e.exposure) begin
                  $display("%0t exposure expected %h actual %h", $time, e.exposure,
                     rsp_exposure);
                  errors++;
               end
               if (rsp_target_exposure !== e.target) begin
                  $display("%0t target expected %h actual %h", $time, e.target,
                     rsp_target_exposure);
                  errors++;
               end
               if (rsp_applied !== e.applied) begin
                  $display("%0t applied expected %b actual %b", $time, e.applied,
                     rsp_applied);
                  errors++;
               end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end else if (!rsp_ready) begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic cmd, input logic [31:0] lum,
         input logic mvalid, input logic [15:0] dt, input logic en,
         input logic [31:0] seed, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_avg_luminance <= lum;
      req_measure_valid <= mvalid;
      req_frame_time <= dt;
      req_enable <= en;
      req_seed_exposure <= seed;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(predict_exposure(cmd, lum, mvalid, dt, en, seed));
   endtask

   task automatic frame(input logic [31:0] lum, input logic [15:0] dt);
      send_request(CMD_FRAME, lum, 1'b1, dt, 1'($urandom_range(0, 1)), $urandom());
   endtask

   task automatic seed(input logic en, input logic [31:0] value);
      send_request(CMD_SEED, $urandom(), 1'($urandom_range(0, 1)), 16'($urandom()), en,
         value);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KEY_VALUE:    key_q = {16'd0, value[15:0]};
         CSR_COMPENSATION: comp_q = {16'd0, value[15:0]};
         CSR_MIN_EXPOSURE: min_q = value;
         CSR_MAX_EXPOSURE: max_q = value;
         CSR_SPEED_UP:     up_q = {16'd0, value[15:0]};
         CSR_SPEED_DOWN:   down_q = {16'd0, value[15:0]};
         default: ;
      endcase
   endtask

   task automatic set_limits(input logic [31:0] k, input logic [31:0] c,
         input logic [31:0] lo, input logic [31:0] hi, input logic [31:0] su,
         input logic [31:0] sd);
      wait_drained();
      write_reg(CSR_KEY_VALUE, k);
      write_reg(CSR_COMPENSATION, c);
      write_reg(CSR_MIN_EXPOSURE, lo);
      write_reg(CSR_MAX_EXPOSURE, hi);
      write_reg(CSR_SPEED_UP, su);
      write_reg(CSR_SPEED_DOWN, sd);
      csr_valid <= 1'b0;
   endtask

   task automatic random_lum(output logic [31:0] lum);
      case ($urandom_range(0, 5))
         0: lum = $urandom_range(0, 8);
         1: lum = $urandom();
         2: lum = 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: lum = $urandom_range(1 << 12, 1 << 20);
      endcase
   endtask

   task automatic test_directed();
      frame(32'h0001_0000, 16'd1000);
      seed(1'b1, 32'd0);
      frame(32'h0001_0000, 16'd1000);
      frame(32'h0000_4000, 16'd3000);
      frame(32'h0004_0000, 16'hFFFF);
      frame(32'h0004_0000, 16'd0);
      frame(32'h0000_0000, 16'd1000);
      send_request(CMD_FRAME, 32'h0001_0000, 1'b0, 16'd1000, 1'b0, '0);
      frame(32'd1, 16'd6554);
      frame(32'hFFFF_FFFF, 16'd6555);
      seed(1'b1, 32'h0002_0000);
      frame(32'h0001_0000, 16'd2000);
      seed(1'b1, 32'hFFFF_FFFF);
      frame(32'h0001_0000, 16'd2000);
      seed(1'b0, 32'h0000_1234);
      frame(32'h0001_0000, 16'd2000);
      seed(1'b1, 32'd0);
      frame(32'h0000_8000, 16'd500);
   endtask

   task automatic test_register_extremes();
      set_limits(0, 16'hFFFF, 0, 0, 0, 0);
      seed(1'b1, 32'h0000_0100);
      frame(32'd1, 16'd100);
      frame(32'h0001_0000, 16'd100);
      set_limits(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd5, 16'hFFFF, 16'hFFFF);
      frame(32'd3, 16'hFFFF);
      frame(32'hFFFF_FFFF, 16'hFFFF);
      set_limits(16'd1, 16'd0, 32'd100, 32'hFFFF_FFFF, 16'd1, 16'd1);
      frame(32'h0001_0000, 16'd1);
      frame(32'hFFFF_FFFF, 16'd6554);
   endtask

   task automatic test_random(input int n);
      logic [31:0] lum;
      for (int i = 0; i < n; i++) begin
         if (i % 250 == 0)
            set_limits($urandom_range(0, 3) == 0 ? 0 : $urandom(),
               $urandom_range(0, 1) ? $urandom_range(64, 1024) : $urandom(),
               $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1 << 16),
               $urandom_range(0, 3) == 0 ? 0 : $urandom(),
               $urandom_range(0, 3) == 0 ? 0 : $urandom(),
               $urandom_range(0, 3) == 0 ? 0 : $urandom());
         random_lum(lum);
         case ($urandom_range(0, 19))
            0: seed($urandom_range(0, 3) != 0, $urandom_range(0, 1) ? $urandom() : 0);
            1: send_request(CMD_FRAME, lum, 1'($urandom_range(0, 1)), 16'($urandom()),
                  1'($urandom_range(0, 1)), $urandom());
            default: begin
               if (!en_q) seed(1'b1, $urandom());
               frame(lum, 16'($urandom_range(0, 1) ? $urandom_range(0, 7000) : $urandom()));
            end
         endcase
      end
   endtask

   initial begin
      key_q = {16'd0, KEY_DEFAULT}; comp_q = 256; min_q = MIN_EXP_DEFAULT;
      max_q = 1048576;
      up_q = 768; down_q = 256;
      exp_q = 0; tgt_q = 0; have_q = 0; en_q = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_random(1250);
      wait_drained();
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
